// File: hdl/uvst_pkg.sv
`default_nettype none

package uvst_pkg;

  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LAT_SEGMENTS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LON_SEGMENTS = 4'd1;

  localparam logic [CNT_W-1:0] LAT_FLOOR = 9'd2;
  localparam logic [CNT_W-1:0] LON_FLOOR = 9'd3;

  localparam logic [2:0] V_TL  = 3'd0;
  localparam logic [2:0] V_TR0 = 3'd1;
  localparam logic [2:0] V_BL0 = 3'd2;
  localparam logic [2:0] V_BL1 = 3'd3;
  localparam logic [2:0] V_TR1 = 3'd4;
  localparam logic [2:0] V_BR  = 3'd5;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [30:0] SIN_C0 = 31'd1686629713;
  localparam logic [30:0] SIN_C1 = 31'd693598668;
  localparam logic [30:0] SIN_C2 = 31'd85569306;
  localparam logic [30:0] SIN_C3 = 31'd5026995;
  localparam logic [30:0] SIN_C4 = 31'd172272;

  typedef enum logic [1:0] {
    DIV_LAT,
    DIV_LON,
    DIV_IDLE
  } div_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] lat_index;
    logic [IDX_W-1:0] lon_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               index_bad;
    logic               last_vertex;
  } out_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

// File: hdl/uvst_sin_pipe.sv
`default_nettype none

module uvst_sin_pipe
  import uvst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic        [31:0] phase_i,
  output      logic signed [31:0] sin_o
);

  logic [30:0] x_q [6];
  logic        neg_q [6];
  logic [30:0] x2_q [2:5];
  logic [30:0] t_q [3:6];
  logic signed [31:0] sin_q;

  logic [30:0] x_d;
  logic [61:0] p_x2, p_t2, p_t3, p_t4, p_t5, p_m;

  assign x_d  = phase_i[30] ? (31'h4000_0000 - {1'b0, phase_i[29:0]})
                            : {1'b0, phase_i[29:0]};
  assign p_x2 = 62'(x_q[0]) * 62'(x_q[0]);
  assign p_t2 = 62'(x2_q[2]) * 62'(SIN_C4);
  assign p_t3 = 62'(x2_q[3]) * 62'(t_q[3]);
  assign p_t4 = 62'(x2_q[4]) * 62'(t_q[4]);
  assign p_t5 = 62'(x2_q[5]) * 62'(t_q[5]);
  assign p_m  = 62'(x_q[5]) * 62'(t_q[6]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_d;
      neg_q[0] <= phase_i[31];
      for (int s = 1; s < 6; s++) begin
        x_q[s]   <= x_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
      x2_q[2] <= p_x2[60:30];
      for (int s = 3; s < 6; s++) x2_q[s] <= x2_q[s-1];
      t_q[3] <= SIN_C3 - p_t2[60:30];
      t_q[4] <= SIN_C2 - p_t3[60:30];
      t_q[5] <= SIN_C1 - p_t4[60:30];
      t_q[6] <= SIN_C0 - p_t5[60:30];
      sin_q  <= neg_q[5] ? -$signed({1'b0, p_m[60:30]}) : $signed({1'b0, p_m[60:30]});
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire

// File: hdl/uv_sphere_tile_generator_unit.sv
`default_nettype none

// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_t: tile indices)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (out_t: one vertex)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A new tile is taken as the previous tile's last vertex beat is issued; the vertex
// sequencer issues one vertex beat per cycle while the output is not stalled.
// After reset and after every configuration write the reciprocal unit runs two
// divisions, one per segment count; no tile and no write is taken meanwhile.
// A stalled output freezes the whole vertex pipeline; nothing is dropped.

module uv_sphere_tile_generator_unit
  import uvst_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned FRAC_BITS    = 15
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire in_t                  in_data_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      out_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CNT_W-1:0]     cfg_data_i
);

  localparam int unsigned SH_N = 30 - FRAC_BITS;
  localparam logic [15:0] CAP_POS = (FRAC_BITS >= 15) ? 16'd32767
                                                      : 16'((1 << FRAC_BITS) - 1);
  localparam logic [5:0] DIV_LAST = 6'd32;
  localparam int unsigned SIN_DEPTH = 7;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] fl);
    logic [CNT_W-1:0] v;
    v = r;
    if (r < fl) v = fl;
    else if (11'(r) > 11'(MAX_SEGMENTS)) v = CNT_W'(MAX_SEGMENTS);
    return v;
  endfunction

  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ua, ub;
    logic [63:0] p;
    logic [31:0] m;
    neg = a[31] ^ b[31];
    ua  = a[31] ? 32'(-a) : 32'(a);
    ub  = b[31] ? 32'(-b) : 32'(b);
    p   = 64'(ua) * 64'(ub) + 64'h2000_0000;
    m   = p[61:30];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [15:0] to_out(input logic signed [31:0] v, input int sh);
    logic        neg;
    logic [33:0] mag;
    neg = v[31];
    mag = neg ? 34'(-$signed({v[31], v})) : 34'({1'b0, v});
    if (sh > 0) mag = (mag + (34'd1 << (sh - 1))) >> sh;
    if (neg) begin
      if (mag > 34'd32768) mag = 34'd32768;
      return 16'(-mag);
    end
    if (mag > 34'(CAP_POS)) mag = 34'(CAP_POS);
    return mag[15:0];
  endfunction

  // configuration and reciprocal unit
  logic [CNT_W-1:0] lat_seg_q, lon_seg_q, lat_eff, lon_eff;
  div_state_e       div_state_q, div_state_d;
  logic [5:0]       step_q;
  logic [CNT_W-1:0] rem_q, rem_nx, div_den;
  logic [31:0]      quo_q, quo_nx;
  logic [CNT_W:0]   rem_sh;
  logic             div_ge, div_on, div_end;
  logic [31:0]      lat_a_q, lon_a_q;
  logic [CNT_W-1:0] lat_b_q, lon_b_q;
  logic [17:0]      lat_r_q, lon_r_q;

  assign lat_eff = eff_count(lat_seg_q, LAT_FLOOR);
  assign lon_eff = eff_count(lon_seg_q, LON_FLOOR);

  always_comb begin
    div_state_d = div_state_q;
    case (div_state_q)
      DIV_LAT:  if (step_q == DIV_LAST) div_state_d = DIV_LON;
      DIV_LON:  if (step_q == DIV_LAST) div_state_d = DIV_IDLE;
      DIV_IDLE: if (cfg_valid_i) div_state_d = DIV_LAT;
      default:  div_state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready_o = 1'b0;
    div_on      = 1'b0;
    div_den     = lat_eff;
    case (div_state_q)
      DIV_LAT:  div_on = 1'b1;
      DIV_LON: begin
        div_on  = 1'b1;
        div_den = lon_eff;
      end
      DIV_IDLE: cfg_ready_o = 1'b1;
      default:  cfg_ready_o = 1'b0;
    endcase
  end

  assign rem_sh  = {rem_q, step_q == 6'd0};
  assign div_ge  = rem_sh >= {1'b0, div_den};
  assign rem_nx  = div_ge ? CNT_W'(rem_sh - {1'b0, div_den}) : CNT_W'(rem_sh);
  assign quo_nx  = {quo_q[30:0], div_ge};
  assign div_end = div_on && (step_q == DIV_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_LAT;
      step_q      <= '0;
      rem_q       <= '0;
      lat_seg_q   <= LAT_FLOOR;
      lon_seg_q   <= LON_FLOOR;
    end else begin
      div_state_q <= div_state_d;
      if (div_on) begin
        step_q <= div_end ? 6'd0 : step_q + 6'd1;
        rem_q  <= div_end ? '0 : rem_nx;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_LAT_SEGMENTS) lat_seg_q <= cfg_data_i;
        if (cfg_index_i == CFG_LON_SEGMENTS) lon_seg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_on) quo_q <= quo_nx;
    if (div_end && div_state_q == DIV_LAT) begin
      lat_a_q <= {1'b0, quo_nx[31:1]};
      lat_b_q <= quo_nx[0] ? CNT_W'(({1'b0, lat_eff} + {1'b0, rem_nx}) >> 1)
                           : (rem_nx >> 1);
      lat_r_q <= quo_nx[31:14];
    end
    if (div_end && div_state_q == DIV_LON) begin
      lon_a_q <= quo_nx;
      lon_b_q <= rem_nx;
      lon_r_q <= quo_nx[31:14];
    end
  end

  // vertex sequencer
  logic             en;
  logic             seq_valid_q, seq_bad_q;
  logic [2:0]       beat_q;
  logic [IDX_W-1:0] li_q, wj_q;
  logic             take, beat_last;
  logic [CNT_W-1:0] lat_k, lon_k;

  assign en         = !out_valid_o || out_ready_i;
  assign beat_last  = beat_q == V_BR;
  assign in_ready_o = !div_on && (!seq_valid_q || (en && beat_last));
  assign take       = in_valid_i && in_ready_o;
  assign lat_k = {1'b0, li_q} + CNT_W'(beat_q inside {V_BL0, V_BL1, V_BR});
  assign lon_k = {1'b0, wj_q} + CNT_W'(beat_q inside {V_TR0, V_TR1, V_BR});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      beat_q      <= V_TL;
    end else if (take) begin
      seq_valid_q <= 1'b1;
      beat_q      <= V_TL;
    end else if (en && seq_valid_q) begin
      seq_valid_q <= !beat_last;
      beat_q      <= beat_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      li_q      <= in_data_i.lat_index;
      wj_q      <= in_data_i.lon_index;
      seq_bad_q <= ({1'b0, in_data_i.lat_index} >= lat_eff)
                || ({1'b0, in_data_i.lon_index} >= lon_eff);
    end
  end

  // phase pipeline, four stages
  localparam int unsigned NTAG = 4 + SIN_DEPTH + 1;
  tag_t        tag_q [NTAG];
  tag_t        tag_in;
  logic [17:0] d_lat1_q, d_lon1_q, d_lat2_q, d_lon2_q, d_lat3_q, d_lon3_q;
  logic [31:0] ka_lat1_q, ka_lon1_q, ka_lat2_q, ka_lon2_q, ka_lat3_q, ka_lon3_q;
  logic [17:0] q_lat2_q, q_lon2_q, q_lat3_q, q_lon3_q;
  logic [35:0] pr_lat, pr_lon;
  logic [26:0] ql_lat, ql_lon;
  logic [31:0] ph_lat_q, ph_lon_q;
  logic signed [31:0] s_lat, c_lat, s_lon, c_lon;
  logic signed [31:0] nx_q, nz_q, cp_q;
  logic [40:0] ka_lat_p, ka_lon_p;

  assign tag_in   = '{valid: seq_valid_q, bad: seq_bad_q, last: beat_last};
  assign ka_lat_p = 41'(lat_k) * 41'(lat_a_q);
  assign ka_lon_p = 41'(lon_k) * 41'(lon_a_q);
  assign pr_lat   = 36'(d_lat1_q) * 36'(lat_r_q);
  assign pr_lon   = 36'(d_lon1_q) * 36'(lon_r_q);
  assign ql_lat   = 27'(q_lat2_q) * 27'(lat_eff);
  assign ql_lon   = 27'(q_lon2_q) * 27'(lon_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NTAG; s++) tag_q[s] <= '0;
    end else if (en) begin
      tag_q[0] <= tag_in;
      for (int s = 1; s < NTAG; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_lat1_q  <= 18'(lat_k) * 18'(lat_b_q) + 18'(lat_eff >> 1);
      d_lon1_q  <= 18'(lon_k) * 18'(lon_b_q) + 18'(lon_eff >> 1);
      ka_lat1_q <= ka_lat_p[31:0];
      ka_lon1_q <= ka_lon_p[31:0];
      q_lat2_q  <= pr_lat[35:18];
      q_lon2_q  <= pr_lon[35:18];
      d_lat2_q  <= d_lat1_q;
      d_lon2_q  <= d_lon1_q;
      ka_lat2_q <= ka_lat1_q;
      ka_lon2_q <= ka_lon1_q;
      d_lat3_q  <= d_lat2_q - ql_lat[17:0];
      d_lon3_q  <= d_lon2_q - ql_lon[17:0];
      q_lat3_q  <= q_lat2_q;
      q_lon3_q  <= q_lon2_q;
      ka_lat3_q <= ka_lat2_q;
      ka_lon3_q <= ka_lon2_q;
      ph_lat_q  <= ka_lat3_q + 32'(q_lat3_q) + 32'(d_lat3_q >= 18'(lat_eff));
      ph_lon_q  <= ka_lon3_q + 32'(q_lon3_q) + 32'(d_lon3_q >= 18'(lon_eff));
    end
  end

  uvst_sin_pipe u_sin_lat (.clk_i, .en_i(en), .phase_i(ph_lat_q), .sin_o(s_lat));
  uvst_sin_pipe u_cos_lat (.clk_i, .en_i(en),
                           .phase_i(ph_lat_q + QUARTER_TURN), .sin_o(c_lat));
  uvst_sin_pipe u_sin_lon (.clk_i, .en_i(en), .phase_i(ph_lon_q), .sin_o(s_lon));
  uvst_sin_pipe u_cos_lon (.clk_i, .en_i(en),
                           .phase_i(ph_lon_q + QUARTER_TURN), .sin_o(c_lon));

  // normal product and output register
  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= mul_q30(s_lat, c_lon);
      nz_q <= mul_q30(s_lat, s_lon);
      cp_q <= c_lat;
      out_q.pos_x       <= to_out(nx_q, SH_N + 1);
      out_q.pos_y       <= to_out(cp_q, SH_N + 1);
      out_q.pos_z       <= to_out(nz_q, SH_N + 1);
      out_q.norm_x      <= to_out(nx_q, SH_N);
      out_q.norm_y      <= to_out(cp_q, SH_N);
      out_q.norm_z      <= to_out(nz_q, SH_N);
      out_q.index_bad   <= tag_q[NTAG-1].bad;
      out_q.last_vertex <= tag_q[NTAG-1].last;
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= tag_q[NTAG-1].valid;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/uvst_chk.sv
`default_nettype none

module uvst_chk
  import uvst_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire out_t                 out_data_o,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_busy_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> !in_ready_o)
    else $error("tile taken during reciprocal update");

  a_cfg_recalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !cfg_ready_o && !in_ready_o)
    else $error("register write did not start reciprocal update");

endmodule

bind uv_sphere_tile_generator_unit uvst_chk u_chk (
  .clk_i,
  .rst_ni,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .out_data_o,
  .cfg_valid_i,
  .cfg_ready_o
);

`default_nettype wire

// File: dv/uv_sphere_tile_generator_unit_tb.sv
`timescale 1ns / 100ps

module uv_sphere_tile_generator_unit_tb;
  import uvst_pkg::*;

  class tile_scoreboard;
    int unsigned lat_reg = 2;
    int unsigned lon_reg = 3;
    out_t        vertex_q[$];
    int          errors = 0;
    int          beats  = 0;
    int          tiles  = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
      if (idx == CFG_LAT_SEGMENTS) lat_reg = 32'(val);
      else if (idx == CFG_LON_SEGMENTS) lon_reg = 32'(val);
    endfunction

    function int unsigned lat_count();
      int unsigned c;
      c = (lat_reg < LAT_FLOOR) ? LAT_FLOOR : lat_reg;
      return (c > 256) ? 256 : c;
    endfunction

    function int unsigned lon_count();
      int unsigned c;
      c = (lon_reg < LON_FLOOR) ? LON_FLOOR : lon_reg;
      return (c > 256) ? 256 : c;
    endfunction

    function longint sine(logic [31:0] ph);
      longint unsigned x, x2, t;
      x = ph[30] ? ((64'd1 << 30) - ph[29:0]) : ph[29:0];
      x2 = (x * x) >> 30;
      t = SIN_C4;
      t = SIN_C3 - ((x2 * t) >> 30);
      t = SIN_C2 - ((x2 * t) >> 30);
      t = SIN_C1 - ((x2 * t) >> 30);
      t = SIN_C0 - ((x2 * t) >> 30);
      t = (x * t) >> 30;
      return ph[31] ? -longint'(t) : longint'(t);
    endfunction

    function longint mul30(longint a, longint b);
      longint unsigned ua, ub;
      longint m;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      m = longint'((ua * ub + (64'd1 << 29)) >> 30);
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function logic [15:0] to_q15(longint v, int extra);
      longint unsigned mag;
      int sh;
      sh = 15 + extra;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      if (v < 0) begin
        if (mag > 32768) mag = 32768;
        return 16'(-mag);
      end
      if (mag > 32767) mag = 32767;
      return 16'(mag);
    endfunction

    function void note(in_t d);
      int unsigned nl, nw, li, wj;
      logic [31:0] p0, p1, t0, t1, lp, tp;
      logic bad;
      longint sp, cp, nx, nz;
      out_t v;
      nl = lat_count();
      nw = lon_count();
      li = 32'(d.lat_index);
      wj = 32'(d.lon_index);
      bad = (li >= nl) || (wj >= nw);
      p0 = 32'(((longint'(li) << 31) + nl / 2) / nl);
      p1 = 32'(((longint'(li + 1) << 31) + nl / 2) / nl);
      t0 = 32'(((longint'(wj) << 32) + nw / 2) / nw);
      t1 = 32'(((longint'(wj + 1) << 32) + nw / 2) / nw);
      tiles++;
      for (int k = 0; k < 6; k++) begin
        lp = (k == V_BL0 || k == V_BL1 || k == V_BR) ? p1 : p0;
        tp = (k == V_TR0 || k == V_TR1 || k == V_BR) ? t1 : t0;
        sp = sine(lp);
        cp = sine(lp + QUARTER_TURN);
        nx = mul30(sp, sine(tp + QUARTER_TURN));
        nz = mul30(sp, sine(tp));
        v.pos_x = to_q15(nx, 1);
        v.pos_y = to_q15(cp, 1);
        v.pos_z = to_q15(nz, 1);
        v.norm_x = to_q15(nx, 0);
        v.norm_y = to_q15(cp, 0);
        v.norm_z = to_q15(nz, 0);
        v.index_bad = bad;
        v.last_vertex = (k == V_BR);
        vertex_q = {vertex_q, v};
      end
    endfunction

    function void cmp(string nm, int e, int a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
      end
    endfunction

    function void check(out_t a);
      out_t e;
      beats++;
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex beat, expected none, actual %h", $time, a);
        return;
      end
      e = vertex_q.pop_front();
      cmp("pos_x", e.pos_x, a.pos_x);
      cmp("pos_y", e.pos_y, a.pos_y);
      cmp("pos_z", e.pos_z, a.pos_z);
      cmp("norm_x", e.norm_x, a.norm_x);
      cmp("norm_y", e.norm_y, a.norm_y);
      cmp("norm_z", e.norm_z, a.norm_z);
      cmp("index_bad", e.index_bad, a.index_bad);
      cmp("last_vertex", e.last_vertex, a.last_vertex);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  tile_scoreboard sb = new();
  bit  burst = 1'b0;
  int  settings = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  uv_sphere_tile_generator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = burst ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_tile(logic [7:0] li, logic [7:0] wj);
    int n;
    n = burst ? 0 : $urandom_range(0, 13);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{lat_index: li, lon_index: wj};
    do @(posedge clk); while (!in_ready);
    sb.note('{lat_index: li, lon_index: wj});
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.vertex_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_tiles(int count);
    int unsigned nl, nw;
    logic [7:0] li, wj;
    nl = sb.lat_count();
    nw = sb.lon_count();
    for (int k = 0; k < count; k++) begin
      if (k % 20 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        li = 8'($urandom);
        wj = 8'($urandom);
      end else begin
        li = 8'($urandom_range(0, nl - 1));
        wj = 8'($urandom_range(0, nw - 1));
      end
      send_tile(li, wj);
    end
    burst = 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] lat_set [8];
    logic [CNT_W-1:0] lon_set [8];
    lat_set = '{2, 0, 1, 256, 511, 4, 17, 0};
    lon_set = '{3, 0, 2, 256, 300, 8, 33, 0};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_tile(0, 0);
    send_tile(1, 2);
    send_tile(1, 0);
    send_tile(0, 1);
    send_tile(2, 0);
    send_tile(0, 3);
    send_tile(255, 255);
    send_tile(8'haa, 8'h55);
    send_tile(8'h55, 8'haa);
    send_tile(1, 1);
    for (int s = 0; s < 8; s++) begin
      drain();
      if (s == 7) begin
        lat_set[s] = CNT_W'($urandom_range(0, 511));
        lon_set[s] = CNT_W'($urandom_range(0, 511));
      end
      write_cfg(CFG_LAT_SEGMENTS, lat_set[s]);
      write_cfg(CFG_LON_SEGMENTS, lon_set[s]);
      if (s == 2) write_cfg(4'd9, 9'd100);
      settings++;
      if (s == 3) begin
        send_tile(0, 0);
        send_tile(255, 255);
        send_tile(127, 128);
      end
      random_tiles(56);
    end
    drain();
    $display("Checked %0d tiles and %0d vertex beats", sb.tiles, sb.beats);
    $display("across %0d segment-count settings plus reset counts", settings);
    if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timeout with %0d vertex beats outstanding", sb.vertex_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
hdl/uvst_pkg.sv
hdl/uvst_sin_pipe.sv
hdl/uv_sphere_tile_generator_unit.sv
hdl/uvst_chk.sv
dv/uv_sphere_tile_generator_unit_tb.sv
